// ----- rtl/breath_cycle_setpoint_sequencer_assert.svh -----
// Assertion macros for the breath cycle setpoint sequencer.
// Used by the top level; depends on nothing else.
`ifndef BREATH_CYCLE_SETPOINT_SEQUENCER_ASSERT_SVH
`define BREATH_CYCLE_SETPOINT_SEQUENCER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BCSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcss: same-cycle check failed");

// Check cons in the cycle after ante.
`define BCSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcss: next-cycle check failed");

`endif

// ----- rtl/bcss_pkg.sv -----
// Types, codes and constants shared by the breath cycle setpoint sequencer.
// No dependencies.
package bcss_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned IDX_W    = 3;

    localparam logic [TICK_W-1:0] DWELL_TICKS = 16'd100;

    localparam logic [IDX_W-1:0] REG_PEEP          = 3'd0;
    localparam logic [IDX_W-1:0] REG_PEAK          = 3'd1;
    localparam logic [IDX_W-1:0] REG_PLATEAU       = 3'd2;
    localparam logic [IDX_W-1:0] REG_RISE          = 3'd3;
    localparam logic [IDX_W-1:0] REG_FALL          = 3'd4;
    localparam logic [IDX_W-1:0] REG_INSPIRE_TICKS = 3'd5;
    localparam logic [IDX_W-1:0] REG_PLATEAU_TICKS = 3'd6;
    localparam logic [IDX_W-1:0] REG_EXPIRE_TICKS  = 3'd7;

    localparam logic [CODE_W-1:0] CODE_RESET   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_INSPIRE = 3'd1;
    localparam logic [CODE_W-1:0] CODE_PLATEAU = 3'd2;
    localparam logic [CODE_W-1:0] CODE_EXPIRE  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DWELL   = 3'd4;

    typedef enum logic [4:0] {
        PH_RESET   = 5'b00001,
        PH_INSPIRE = 5'b00010,
        PH_PLATEAU = 5'b00100,
        PH_EXPIRE  = 5'b01000,
        PH_DWELL   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0] peep_level;
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] plateau_level;
        logic [LEVEL_W-1:0] rise_step;
        logic [LEVEL_W-1:0] fall_step;
        logic [TICK_W-1:0]  inspire_ticks;
        logic [TICK_W-1:0]  plateau_ticks;
        logic [TICK_W-1:0]  expire_ticks;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] setpoint;
        logic [CODE_W-1:0]  phase;
    } t_seq_out;

    function automatic logic [CODE_W-1:0] phase_code(input t_phase ph);
        logic [CODE_W-1:0] code;
        unique case (ph)
            PH_INSPIRE: code = CODE_INSPIRE;
            PH_PLATEAU: code = CODE_PLATEAU;
            PH_EXPIRE:  code = CODE_EXPIRE;
            PH_DWELL:   code = CODE_DWELL;
            default:    code = CODE_RESET;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/bcss_cfg.sv -----
// Configuration register file of the breath cycle setpoint sequencer.
// Depends on bcss_pkg.
module bcss_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcss_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [bcss_pkg::TICK_W-1:0]    i_cfg_data,
    output bcss_pkg::t_cfg                 o_cfg
);
    import bcss_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peep_level    <= 8'd0;
            r_cfg.peak_level    <= 8'd255;
            r_cfg.plateau_level <= 8'd0;
            r_cfg.rise_step     <= 8'd1;
            r_cfg.fall_step     <= 8'd1;
            r_cfg.inspire_ticks <= 16'd0;
            r_cfg.plateau_ticks <= 16'd0;
            r_cfg.expire_ticks  <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PEEP:          r_cfg.peep_level    <= i_cfg_data[LEVEL_W-1:0];
                REG_PEAK:          r_cfg.peak_level    <= i_cfg_data[LEVEL_W-1:0];
                REG_PLATEAU:       r_cfg.plateau_level <= i_cfg_data[LEVEL_W-1:0];
                REG_RISE:          r_cfg.rise_step     <= i_cfg_data[LEVEL_W-1:0];
                REG_FALL:          r_cfg.fall_step     <= i_cfg_data[LEVEL_W-1:0];
                REG_INSPIRE_TICKS: r_cfg.inspire_ticks <= i_cfg_data;
                REG_PLATEAU_TICKS: r_cfg.plateau_ticks <= i_cfg_data;
                REG_EXPIRE_TICKS:  r_cfg.expire_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/bcss_scale.sv -----
// Scales a 10-bit pressure sample to 0..255 (sample * 255 / 1023, truncated).
// Depends on bcss_pkg.
module bcss_scale (
    input  logic [bcss_pkg::SAMPLE_W-1:0] i_sample,
    output logic [bcss_pkg::LEVEL_W-1:0]  o_level
);
    import bcss_pkg::*;

    logic [17:0] w_prod;
    logic [17:0] w_acc;

    // divide by 1023 as (x + x/1024 + 1) / 1024, exact for every x here (x = sample * 255, at most 260865)
    assign w_prod  = {i_sample, 8'd0} - {8'd0, i_sample};
    assign w_acc   = w_prod + {10'd0, w_prod[17:10]} + 18'd1;
    assign o_level = w_acc[17:10];

endmodule

// ----- rtl/bcss_seq.sv -----
// Phase sequencer: phase, tick counter and setpoint state, next result values.
// Depends on bcss_pkg.
module bcss_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  bcss_pkg::t_cfg      i_cfg,
    output bcss_pkg::t_seq_out  o_next
);
    import bcss_pkg::*;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [TICK_W-1:0]   r_count;
    logic [TICK_W-1:0]   n_count;
    logic [LEVEL_W-1:0]  r_setpoint;
    logic [LEVEL_W-1:0]  n_setpoint;

    logic [TICK_W-1:0]   w_inc;
    logic [TICK_W-1:0]   w_limit;
    logic                w_done;
    logic [LEVEL_W:0]    w_sum;
    logic [LEVEL_W:0]    w_diff;

    assign w_inc  = (r_count == {TICK_W{1'b1}}) ? r_count : r_count + 16'd1;
    assign w_done = w_inc > w_limit;
    assign w_sum  = {1'b0, r_setpoint} + {1'b0, i_cfg.rise_step};
    assign w_diff = {1'b0, r_setpoint} - {1'b0, i_cfg.fall_step};

    always_comb begin
        unique case (r_phase)
            PH_INSPIRE: w_limit = i_cfg.inspire_ticks;
            PH_PLATEAU: w_limit = i_cfg.plateau_ticks;
            PH_EXPIRE:  w_limit = i_cfg.expire_ticks;
            default:    w_limit = DWELL_TICKS;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = w_done ? '0 : w_inc;
        n_setpoint = r_setpoint;
        unique case (r_phase)
            PH_RESET: begin
                n_phase    = PH_INSPIRE;
                n_count    = '0;
                n_setpoint = i_cfg.peep_level;
            end
            PH_INSPIRE: begin
                n_setpoint = (w_sum > {1'b0, i_cfg.peak_level}) ? i_cfg.peak_level
                                                               : w_sum[LEVEL_W-1:0];
                if (w_done) n_phase = PH_PLATEAU;
            end
            PH_PLATEAU: begin
                n_setpoint = i_cfg.plateau_level;
                if (w_done) n_phase = PH_EXPIRE;
            end
            PH_EXPIRE: begin
                n_setpoint = (w_diff[LEVEL_W] || (w_diff[LEVEL_W-1:0] < i_cfg.peep_level))
                             ? i_cfg.peep_level : w_diff[LEVEL_W-1:0];
                if (w_done) n_phase = PH_DWELL;
            end
            PH_DWELL: begin
                n_setpoint = i_cfg.peep_level;
                if (w_done) n_phase = PH_RESET;
            end
            default: begin
                n_phase = PH_RESET;
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RESET;
            r_count    <= '0;
            r_setpoint <= '0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_setpoint <= n_setpoint;
        end
    end

    assign o_next.setpoint = n_setpoint;
    assign o_next.phase    = phase_code(n_phase);

endmodule

// ----- rtl/breath_cycle_setpoint_sequencer.sv -----
// Breath cycle setpoint sequencer, top level.
// Depends on bcss_pkg, bcss_cfg, bcss_seq, bcss_scale and the assertion header.
//
// Usage:
//   s_axis carries one control tick per item: tdata[9:0] is the raw pressure sample.
//   m_axis returns one result per tick: setpoint, phase code (0 reset, 1 inspire,
//   2 plateau, 3 expire, 4 dwell) and the sample scaled to 0..255.
//   The i_cfg_* port writes one of eight registers per cycle; write only while
//   no tick is in flight.
//   A tick is accepted into the input register, then its result is registered.
//   One tick is taken per cycle while m_axis_tready is high: the input register
//   feeds the phase update and scaling logic, which load the result register;
//   the phase/counter/setpoint state is the only loop, updated from its own value.
//   When m_axis_tready is low the result holds and one more tick can wait in the
//   input register; s_axis_tready drops only when both are full.
//   Synchronous active-low reset empties both registers, returns the sequencer
//   to the reset phase with counter and setpoint at zero, and restores register
//   defaults (peak 255, rise and fall steps 1, all else 0).
module breath_cycle_setpoint_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] pressure_sample, [15:10] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] setpoint, [10:8] phase,
                                       // [18:11] measured_level, [23:19] zero
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import bcss_pkg::*;

    `include "breath_cycle_setpoint_sequencer_assert.svh"

    t_cfg                w_cfg;
    t_seq_out            w_next;
    logic [LEVEL_W-1:0]  w_level;
    logic                w_adv;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_out_setpoint;
    logic [CODE_W-1:0]   r_out_phase;
    logic [LEVEL_W-1:0]  r_out_level;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;

    bcss_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bcss_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv && r_in_valid),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    bcss_scale u_scale (
        .i_sample (r_in_sample),
        .o_level  (w_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (w_adv) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
        if (w_adv && r_in_valid) begin
            r_out_setpoint <= w_next.setpoint;
            r_out_phase    <= w_next.phase;
            r_out_level    <= w_level;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_level, r_out_phase, r_out_setpoint};

    `BCSS_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid)
    `BCSS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv,
                      r_in_valid && $stable(r_in_sample))
    `BCSS_ASSERT_NOW(a_reset_peep, i_clk, i_rst_n, r_out_valid && r_out_phase == CODE_RESET,
                     r_out_setpoint == w_cfg.peep_level)

endmodule
